### rtl/core/biz_pkg.sv
package biz_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_FACTOR = 16;

  localparam int POS_W      = 12;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int BLEND_LAT  = CH_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int ZF_W       = 5;
  localparam int SIZE_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_ZOOM_IN  = 1'b0;
  localparam logic MODE_ZOOM_OUT = 1'b1;

  localparam logic [ZF_W-1:0]   RST_ZOOM_FACTOR = 5'd1;
  localparam logic [SIZE_W-1:0] RST_SIZE        = 9'd256;

endpackage

### rtl/core/biz_ram.sv
module biz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/biz_divpipe.sv
module biz_divpipe #(
  parameter int NW = 13,
  parameter int QW = 12,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign lo_in  = num[QW-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign q_in   = quo_r[i-1];
    end

    assign trial   = {rem_in, lo_in[QW-1]};
    assign ge      = (trial >= {1'b0, den});
    assign rem_nxt = ge ? DW'(trial - {1'b0, den}) : DW'(trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        lo_r[i]  <= lo_in << 1;
        quo_r[i] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1];

endmodule

### rtl/core/biz_blend_lane.sv
module biz_blend_lane import biz_pkg::*; #(
  parameter int FW = 5
) (
  input  logic            clk,
  input  logic            en,
  input  logic [CH_W-1:0] a,
  input  logic [CH_W-1:0] b,
  input  logic [FW-1:0]   r,
  input  logic [FW-1:0]   f,
  output logic [CH_W-1:0] c
);

  localparam int NW = CH_W + FW;

  logic [NW-1:0] a_w;
  logic [NW-1:0] b_w;
  logic [NW-1:0] fr_w;
  logic [NW-1:0] r_w;
  logic [NW-1:0] num_nxt;
  logic [NW-1:0] num_r;

  assign a_w     = NW'(a);
  assign b_w     = NW'(b);
  assign fr_w    = NW'(FW'(f - r));
  assign r_w     = NW'(r);
  assign num_nxt = NW'(a_w * fr_w + b_w * r_w);

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
    end
  end

  biz_divpipe #(.NW(NW), .QW(CH_W), .DW(FW)) u_div (
    .clk (clk),
    .en  (en),
    .num (num_r),
    .den (f),
    .quo (c),
    .rem ()
  );

endmodule

### rtl/core/bilinear_integer_zoom_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_opcode, in_pos_x, in_pos_y, in_red..in_alpha
// out      output     out_valid / out_stall out_red..out_alpha, out_of_range
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; only a read beat yields a result.
// The pipeline runs through the 12-stage coordinate divider, the bank read and two 9-stage
// blend lanes in series; the frame store is split into four banks by pixel parity.
// Reset clears the pipeline valids and loads the default configuration; frame store kept.
// A stalled result holds the whole pipeline, so in_stall follows out_valid and out_stall.
module bilinear_integer_zoom_unit import biz_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_alpha,
  output logic                  out_of_range,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FW         = $clog2(MAX_FACTOR + 1);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int PW         = POS_W + 1 + FW;
  localparam int DL         = 2 * BLEND_LAT;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] pix;
    logic [PW-1:0]    px;
    logic [PW-1:0]    py;
  } front_t;

  typedef struct packed {
    logic             op;
    logic             oor;
    logic             ok;
    logic [CW-1:0]    col0;
    logic [CW-1:0]    col1;
    logic [RW-1:0]    row0;
    logic [RW-1:0]    row1;
    logic [FW-1:0]    rx;
    logic [FW-1:0]    ry;
    logic [PIX_W-1:0] pix;
  } mid_t;

  typedef struct packed {
    logic          op;
    logic          oor;
    logic [FW-1:0] rx;
    logic [FW-1:0] ry;
    logic          c0p;
    logic          c1p;
    logic          r0p;
    logic          r1p;
  } back_t;

  typedef struct packed {
    logic          op;
    logic          oor;
    logic [FW-1:0] ry;
  } tail_t;

  logic [ZF_W-1:0]   zoom_factor_r;
  logic              zoom_mode_r;
  logic [SIZE_W-1:0] source_width_r;
  logic [SIZE_W-1:0] source_height_r;

  logic [FW-1:0] f_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_factor_r   <= RST_ZOOM_FACTOR;
      zoom_mode_r     <= MODE_ZOOM_IN;
      source_width_r  <= RST_SIZE;
      source_height_r <= RST_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZOOM_FACTOR:   zoom_factor_r   <= cfg_data[ZF_W-1:0];
        REG_ZOOM_MODE:     zoom_mode_r     <= cfg_data[0];
        REG_SOURCE_WIDTH:  source_width_r  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (zoom_factor_r == '0) begin
      f_eff = FW'(1);
    end else if (int'(zoom_factor_r) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(zoom_factor_r);
    end
    if (source_width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(source_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(source_width_r);
    end
    if (source_height_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(source_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(source_height_r);
    end
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  logic             s0_v_r;
  front_t           s0_r;
  logic [POS_W-1:0] fr_v_r;
  front_t           fr_r [POS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      fr_v_r <= '0;
    end else if (advance) begin
      s0_v_r <= in_valid;
      fr_v_r <= {fr_v_r[POS_W-2:0], s0_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_r.op  <= in_opcode;
      s0_r.x   <= in_pos_x;
      s0_r.y   <= in_pos_y;
      s0_r.pix <= {in_alpha, in_blue, in_green, in_red};
      s0_r.px  <= PW'(((POS_W + 1)'(in_pos_x) + 1'b1) * f_eff);
      s0_r.py  <= PW'(((POS_W + 1)'(in_pos_y) + 1'b1) * f_eff);
      fr_r[0]  <= s0_r;
      for (int k = 1; k < POS_W; k++) begin
        fr_r[k] <= fr_r[k-1];
      end
    end
  end

  logic [POS_W-1:0] qx;
  logic [POS_W-1:0] qy;
  logic [FW-1:0]    rem_x;
  logic [FW-1:0]    rem_y;

  biz_divpipe #(.NW(POS_W + 1), .QW(POS_W), .DW(FW)) u_div_x (
    .clk (clk),
    .en  (advance),
    .num ({1'b0, s0_r.x}),
    .den (f_eff),
    .quo (qx),
    .rem (rem_x)
  );

  biz_divpipe #(.NW(POS_W + 1), .QW(POS_W), .DW(FW)) u_div_y (
    .clk (clk),
    .en  (advance),
    .num ({1'b0, s0_r.y}),
    .den (f_eff),
    .quo (qy),
    .rem (rem_y)
  );

  front_t         ft;
  mid_t           ma_nxt;
  mid_t           ma_r;
  logic           ma_v_r;
  logic [POS_W:0] x0n;
  logic [POS_W:0] y0n;
  logic [PW-1:0]  ax;
  logic [PW-1:0]  ay;

  assign ft  = fr_r[POS_W-1];
  assign x0n = (POS_W + 1)'(qx) + 1'b1;
  assign y0n = (POS_W + 1)'(qy) + 1'b1;
  assign ax  = ft.px - PW'(f_eff);
  assign ay  = ft.py - PW'(f_eff);

  always_comb begin
    ma_nxt      = '0;
    ma_nxt.op   = ft.op;
    ma_nxt.pix  = ft.pix;
    if (ft.op == OP_WRITE) begin
      ma_nxt.ok   = (int'(ft.x) < MAX_WIDTH) && (int'(ft.y) < MAX_HEIGHT);
      ma_nxt.col0 = CW'(ft.x);
      ma_nxt.col1 = CW'(ft.x);
      ma_nxt.row0 = RW'(ft.y);
      ma_nxt.row1 = RW'(ft.y);
    end else if (zoom_mode_r == MODE_ZOOM_IN) begin
      ma_nxt.oor  = !((qx < w_eff) && (qy < h_eff));
      ma_nxt.col0 = CW'(qx);
      ma_nxt.col1 = (x0n < w_eff) ? CW'(x0n) : CW'(qx);
      ma_nxt.row0 = RW'(qy);
      ma_nxt.row1 = (y0n < h_eff) ? RW'(y0n) : RW'(qy);
      ma_nxt.rx   = rem_x;
      ma_nxt.ry   = rem_y;
    end else begin
      ma_nxt.oor  = !((ft.px <= w_eff) && (ft.py <= h_eff));
      ma_nxt.col0 = CW'(ax);
      ma_nxt.col1 = CW'(ax);
      ma_nxt.row0 = RW'(ay);
      ma_nxt.row1 = RW'(ay);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_v_r <= 1'b0;
    end else if (advance) begin
      ma_v_r <= fr_v_r[POS_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ma_r <= ma_nxt;
    end
  end

  logic [PIX_W-1:0] bank_q [4];
  logic [3:0]       ram_we;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
    logic [BAW-1:0] addr;

    assign col  = (ma_r.col0[0] == BX) ? ma_r.col0 : ma_r.col1;
    assign row  = (ma_r.row0[0] == BY) ? ma_r.row0 : ma_r.row1;
    assign addr = BAW'((row >> 1) * HALF_W + (col >> 1));
    assign ram_we[b] = advance && ma_v_r && (ma_r.op == OP_WRITE) && ma_r.ok &&
                       (ma_r.col0[0] == BX) && (ma_r.row0[0] == BY);

    biz_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (addr),
      .wdata (ma_r.pix),
      .re    (advance),
      .raddr (addr),
      .rdata (bank_q[b])
    );
  end

  back_t mb_r;
  logic  mb_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mb_v_r <= 1'b0;
    end else if (advance) begin
      mb_v_r <= ma_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mb_r.op  <= ma_r.op;
      mb_r.oor <= ma_r.oor;
      mb_r.rx  <= ma_r.rx;
      mb_r.ry  <= ma_r.ry;
      mb_r.c0p <= ma_r.col0[0];
      mb_r.c1p <= ma_r.col1[0];
      mb_r.r0p <= ma_r.row0[0];
      mb_r.r1p <= ma_r.row1[0];
    end
  end

  logic [PIX_W-1:0] p00;
  logic [PIX_W-1:0] p10;
  logic [PIX_W-1:0] p01;
  logic [PIX_W-1:0] p11;

  assign p00 = bank_q[{mb_r.r0p, mb_r.c0p}];
  assign p10 = bank_q[{mb_r.r0p, mb_r.c1p}];
  assign p01 = bank_q[{mb_r.r1p, mb_r.c0p}];
  assign p11 = bank_q[{mb_r.r1p, mb_r.c1p}];

  tail_t          dl_r [DL];
  logic [DL-1:0]  dl_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_v_r <= '0;
    end else if (advance) begin
      dl_v_r <= {dl_v_r[DL-2:0], mb_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dl_r[0].op  <= mb_r.op;
      dl_r[0].oor <= mb_r.oor;
      dl_r[0].ry  <= mb_r.ry;
      for (int k = 1; k < DL; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  logic [PIX_W-1:0] h_top;
  logic [PIX_W-1:0] h_bot;
  logic [PIX_W-1:0] v_pix;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    biz_blend_lane #(.FW(FW)) u_top (
      .clk (clk),
      .en  (advance),
      .a   (p00[ch*CH_W +: CH_W]),
      .b   (p10[ch*CH_W +: CH_W]),
      .r   (mb_r.rx),
      .f   (f_eff),
      .c   (h_top[ch*CH_W +: CH_W])
    );

    biz_blend_lane #(.FW(FW)) u_bot (
      .clk (clk),
      .en  (advance),
      .a   (p01[ch*CH_W +: CH_W]),
      .b   (p11[ch*CH_W +: CH_W]),
      .r   (mb_r.rx),
      .f   (f_eff),
      .c   (h_bot[ch*CH_W +: CH_W])
    );

    biz_blend_lane #(.FW(FW)) u_vert (
      .clk (clk),
      .en  (advance),
      .a   (h_top[ch*CH_W +: CH_W]),
      .b   (h_bot[ch*CH_W +: CH_W]),
      .r   (dl_r[BLEND_LAT-1].ry),
      .f   (f_eff),
      .c   (v_pix[ch*CH_W +: CH_W])
    );
  end

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dl_v_r[DL-1] && (dl_r[DL-1].op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix_r <= dl_r[DL-1].oor ? '0 : v_pix;
      out_oor_r <= dl_r[DL-1].oor;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_pix_r[0*CH_W +: CH_W];
  assign out_green    = out_pix_r[1*CH_W +: CH_W];
  assign out_blue     = out_pix_r[2*CH_W +: CH_W];
  assign out_alpha    = out_pix_r[3*CH_W +: CH_W];
  assign out_of_range = out_oor_r;

  a_one_bank_written: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ram_we))
    else $error("more than one frame bank written in a cycle");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_of_range) |->
      (out_red == '0 && out_green == '0 && out_blue == '0 && out_alpha == '0))
    else $error("out-of-range result carries nonzero channels");

  a_neighbor_col: assert property (@(posedge clk) disable iff (!rst_n)
    (ma_v_r && ma_r.op == OP_READ && !ma_r.oor) |->
      (ma_r.col1 == ma_r.col0 || ma_r.col1 == CW'(ma_r.col0 + 1'b1)))
    else $error("right neighbor column is not adjacent");

  a_neighbor_row: assert property (@(posedge clk) disable iff (!rst_n)
    (ma_v_r && ma_r.op == OP_READ && !ma_r.oor) |->
      (ma_r.row1 == ma_r.row0 || ma_r.row1 == RW'(ma_r.row0 + 1'b1)))
    else $error("lower neighbor row is not adjacent");

endmodule

### sim/bilinear_integer_zoom_unit_test.sv
module bilinear_integer_zoom_unit_test;
  import biz_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            oor;
  } zoom_pixel_t;

  typedef struct {
    logic             op;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PIX_W-1:0] rgba;
    bit               typed;
    zoom_pixel_t      px;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OP_WRITE;
  logic [POS_W-1:0] in_pos_x = '0;
  logic [POS_W-1:0] in_pos_y = '0;
  logic [CH_W-1:0] in_red = '0;
  logic [CH_W-1:0] in_green = '0;
  logic [CH_W-1:0] in_blue = '0;
  logic [CH_W-1:0] in_alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bilinear_integer_zoom_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [PIX_W-1:0] frame_mem [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  int unsigned zf_reg = RST_ZOOM_FACTOR;
  int unsigned mode_reg = MODE_ZOOM_IN;
  int unsigned width_reg = RST_SIZE;
  int unsigned height_reg = RST_SIZE;

  zoom_pixel_t pending_pixels[$];
  int fail_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold_req = 0;
  int hold_left = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_factor();
    return clamp_size(zf_reg, DEF_MAX_FACTOR);
  endfunction

  function automatic int unsigned eff_width();
    return clamp_size(width_reg, DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_size(height_reg, DEF_MAX_HEIGHT);
  endfunction

  function automatic int unsigned out_w();
    return (mode_reg == MODE_ZOOM_IN) ? eff_width() * eff_factor() : eff_width() / eff_factor();
  endfunction

  function automatic int unsigned out_h();
    return (mode_reg == MODE_ZOOM_IN) ? eff_height() * eff_factor()
                                      : eff_height() / eff_factor();
  endfunction

  function automatic logic [PIX_W-1:0] fetch_pixel(int unsigned x, int unsigned y);
    if (x >= DEF_MAX_WIDTH || y >= DEF_MAX_HEIGHT) return '0;
    return frame_mem[y * DEF_MAX_WIDTH + x];
  endfunction

  function automatic logic [PIX_W-1:0] lerp_rgba(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q,
                                                  int unsigned r, int unsigned f);
    logic [PIX_W-1:0] res;
    int unsigned a;
    int unsigned b;
    res = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      a = p[c*CH_W +: CH_W];
      b = q[c*CH_W +: CH_W];
      res[c*CH_W +: CH_W] = CH_W'((a * (f - r) + b * r) / f);
    end
    return res;
  endfunction

  function automatic zoom_pixel_t zoom_read(int unsigned x, int unsigned y);
    zoom_pixel_t px;
    logic [PIX_W-1:0] pix, top, bot;
    int unsigned f, w, h, x0, y0, x1, y1;
    f = eff_factor();
    w = eff_width();
    h = eff_height();
    px = '0;
    if (x >= out_w() || y >= out_h()) begin
      px.oor = 1'b1;
      return px;
    end
    if (mode_reg == MODE_ZOOM_IN) begin
      x0 = x / f;
      y0 = y / f;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      top = lerp_rgba(fetch_pixel(x0, y0), fetch_pixel(x1, y0), x % f, f);
      bot = lerp_rgba(fetch_pixel(x0, y1), fetch_pixel(x1, y1), x % f, f);
      pix = lerp_rgba(top, bot, y % f, f);
    end else begin
      pix = fetch_pixel(x * f, y * f);
    end
    px.red = pix[7:0];
    px.green = pix[15:8];
    px.blue = pix[23:16];
    px.alpha = pix[31:24];
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic send_beat(logic op, int unsigned x, int unsigned y, logic [PIX_W-1:0] rgba,
                           bit typed, zoom_pixel_t typed_px);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pos_x <= POS_W'(x);
    in_pos_y <= POS_W'(y);
    in_red <= rgba[7:0];
    in_green <= rgba[15:8];
    in_blue <= rgba[23:16];
    in_alpha <= rgba[31:24];
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) begin
      if (x < DEF_MAX_WIDTH && y < DEF_MAX_HEIGHT) frame_mem[y * DEF_MAX_WIDTH + x] = rgba;
    end else begin
      pending_pixels.push_back(typed ? typed_px : zoom_read(x, y));
    end
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ZOOM_FACTOR: zf_reg = val & 5'h1F;
      REG_ZOOM_MODE: mode_reg = val & 1;
      REG_SOURCE_WIDTH: width_reg = val & 9'h1FF;
      default: height_reg = val & 9'h1FF;
    endcase
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    zoom_pixel_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red !== exp_px.red) report_mismatch($sformatf("red %0h exp %0h",
                                                   out_red, exp_px.red));
        if (out_green !== exp_px.green) report_mismatch($sformatf("green %0h exp %0h",
                                                       out_green, exp_px.green));
        if (out_blue !== exp_px.blue) report_mismatch($sformatf("blue %0h exp %0h",
                                                     out_blue, exp_px.blue));
        if (out_alpha !== exp_px.alpha) report_mismatch($sformatf("alpha %0h exp %0h",
                                                       out_alpha, exp_px.alpha));
        if (out_of_range !== exp_px.oor) report_mismatch($sformatf("range flag %0b exp %0b",
                                                        out_of_range, exp_px.oor));
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  localparam zoom_pixel_t OOR_PX = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0, oor: 1'b1};

  stim_row_t directed[] = '{
    '{OP_READ, 12'd4095, 12'd4095, 32'h0, 1, OOR_PX},
    '{OP_READ, 12'd256, 12'd0, 32'h0, 1, OOR_PX},
    '{OP_READ, 12'd0, 12'd256, 32'h0, 1, OOR_PX},
    '{OP_WRITE, 12'd0, 12'd0, 32'hFF00FF00, 0, '0},
    '{OP_WRITE, 12'd1, 12'd0, 32'h00FF00FF, 0, '0},
    '{OP_WRITE, 12'd0, 12'd1, 32'hFFFFFFFF, 0, '0},
    '{OP_WRITE, 12'd1, 12'd1, 32'h00000000, 0, '0},
    '{OP_WRITE, 12'd2, 12'd0, 32'h11223344, 0, '0},
    '{OP_WRITE, 12'd2, 12'd1, 32'h99AABBCC, 0, '0},
    '{OP_WRITE, 12'd0, 12'd2, 32'h0F1E2D3C, 0, '0},
    '{OP_WRITE, 12'd1, 12'd2, 32'hC3B2A190, 0, '0},
    '{OP_WRITE, 12'd255, 12'd255, 32'h12345678, 0, '0},
    '{OP_WRITE, 12'd256, 12'd0, 32'hAAAAAAAA, 0, '0},
    '{OP_WRITE, 12'd0, 12'd4095, 32'h55555555, 0, '0},
    '{OP_READ, 12'd0, 12'd0, 32'h0, 1,
      '{red: 8'h00, green: 8'hFF, blue: 8'h00, alpha: 8'hFF, oor: 1'b0}},
    '{OP_READ, 12'd255, 12'd255, 32'h0, 1,
      '{red: 8'h78, green: 8'h56, blue: 8'h34, alpha: 8'h12, oor: 1'b0}},
    '{OP_READ, 12'd1, 12'd0, 32'h0, 0, '0},
    '{OP_READ, 12'd0, 12'd1, 32'h0, 0, '0}
  };

  int unsigned phase_cfg[10][4] = '{
    '{1, 0, 4, 4}, '{16, 0, 3, 2}, '{2, 1, 8, 6}, '{16, 1, 20, 17}, '{3, 1, 2, 2},
    '{0, 0, 5, 1}, '{31, 0, 2, 3}, '{5, 1, 5, 300}, '{1, 0, 0, 3}, '{16, 1, 511, 16}
  };

  initial begin
    int unsigned w, h, ow, oh, x, y, f;
    logic op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_beat(directed[i].op, directed[i].x, directed[i].y, directed[i].rgba,
                directed[i].typed, directed[i].px);
    for (int ph = 0; ph < 10; ph++) begin
      drain_pipe();
      write_reg(REG_ZOOM_FACTOR, phase_cfg[ph][0]);
      write_reg(REG_ZOOM_MODE, phase_cfg[ph][1]);
      write_reg(REG_SOURCE_WIDTH, phase_cfg[ph][2]);
      write_reg(REG_SOURCE_HEIGHT, phase_cfg[ph][3]);
      idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 68 : 0;
      stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 34 : 0;
      if (ph % 4 == 3) idle_pct = 34;
      w = eff_width();
      h = eff_height();
      f = eff_factor();
      ow = out_w();
      oh = out_h();
      for (int yy = 0; yy < h; yy++)
        for (int xx = 0; xx < w; xx++)
          if (mode_reg == MODE_ZOOM_IN || (xx % f == 0 && yy % f == 0))
            send_beat(OP_WRITE, xx, yy, $urandom, 0, '0);
      if (ph == 2) long_hold_req = 1;
      for (int n = 0; n < 36; n++) begin
        if (ph == 4 && n == 25) begin
          in_valid <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk);
        end
        op = ($urandom_range(99) < 70) ? OP_READ : OP_WRITE;
        if (op == OP_WRITE) begin
          if ($urandom_range(1)) begin
            x = $urandom_range(DEF_MAX_WIDTH - 1);
            y = $urandom_range(DEF_MAX_HEIGHT - 1);
          end else begin
            x = $urandom_range(4095);
            y = $urandom_range(4095);
          end
        end else if (ow > 0 && oh > 0 && $urandom_range(99) < 80) begin
          x = $urandom_range(ow - 1);
          y = $urandom_range(oh - 1);
        end else begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
          if (x < ow && y < oh) x = 4095 - $urandom_range(7);
        end
        send_beat(op, x, y, $urandom, 0, '0);
      end
    end
    drain_pipe();
    if (pending_pixels.size() != 0) report_mismatch("results still expected at end");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
